// ===== design/debounced_button_motor_mode_control_core_macros.svh =====
// Assertion macros for the debounced button motor mode control block.
`ifndef DEBOUNCED_BUTTON_MOTOR_MODE_CONTROL_CORE_MACROS_SVH
`define DEBOUNCED_BUTTON_MOTOR_MODE_CONTROL_CORE_MACROS_SVH
`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define DBMM_ASSERT(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define DBMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DBMM_ASSERT(lbl, clk, rstn, cond)
`define DBMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/dbmm_pkg.sv =====
// Shared types, constants and functions of the debounced button motor mode control block.
package dbmm_pkg;

	localparam int LEVELS      = 5;
	localparam int DUTY_MAX    = 255;
	localparam int COUNT_WIDTH = 16;

	localparam int TICKS_W = 16;
	localparam int DUTY_W  = 8;
	localparam int SPEED_W = 3;
	localparam int MODE_W  = 2;

	localparam int LEVEL_W = $clog2(LEVELS + 1);
	localparam int CMP_W   = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

	localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(50);
	localparam logic [LEVEL_W-1:0] LEVEL_FIRST = LEVEL_W'(1);
	localparam logic [LEVEL_W-1:0] LEVEL_LAST  = LEVEL_W'(LEVELS);

	typedef enum logic [MODE_W-1:0] {
		MODE_STOP  = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2
	} mode_t;

	typedef struct packed {
		logic raw_left;
		logic raw_right;
		logic raw_activate;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty_forward;
		logic [DUTY_W-1:0]  duty_reverse;
		logic [MODE_W-1:0]  motor_mode;
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
	} result_t;

	// Debounced view of one button for the tick being processed.
	typedef struct packed {
		logic stable;
		logic fall;
	} btn_evt_t;

	// PWM duty of a speed level, saturated to the duty field.
	// Every level value has a constant duty, so this reduces to a small lookup table.
	function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
		int cand;
		duty_of = '0;
		for (int l = 0; l < (1 << LEVEL_W); l++) begin
			cand = (l * DUTY_MAX) / LEVELS;
			if (cand > (1 << DUTY_W) - 1) cand = (1 << DUTY_W) - 1;
			if (level == LEVEL_W'(l)) duty_of = DUTY_W'(cand);
		end
	endfunction

	// Next speed level, wrapping from the top level back to the first.
	function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] level);
		next_level = (level >= LEVEL_LAST) ? LEVEL_FIRST : level + LEVEL_W'(1);
	endfunction

endpackage

// ===== design/dbmm_debounce.sv =====
// Debounce lane for one active-low button: settle counter, stable level and falling edge.
module dbmm_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          raw,
	input  logic [dbmm_pkg::TICKS_W-1:0]  ticks,
	output dbmm_pkg::btn_evt_t            evt
);

	logic                              last_q;
	logic                              stable_q;
	logic [dbmm_pkg::COUNT_WIDTH-1:0]  count_q;
	logic [dbmm_pkg::COUNT_WIDTH-1:0]  count_d;
	logic                              stable_d;

	// A raw change restarts the counter; otherwise it counts up and saturates.
	always_comb begin
		if (raw != last_q) begin
			count_d = '0;
		end else if (count_q != {dbmm_pkg::COUNT_WIDTH{1'b1}}) begin
			count_d = count_q + dbmm_pkg::COUNT_WIDTH'(1);
		end else begin
			count_d = count_q;
		end
	end

	// The stable level follows the raw level once it has settled long enough.
	always_comb begin
		if (dbmm_pkg::CMP_W'(count_d) >= dbmm_pkg::CMP_W'(ticks)) begin
			stable_d = raw;
		end else begin
			stable_d = stable_q;
		end
	end

	assign evt.stable = stable_d;
	assign evt.fall   = !stable_d && stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b1;
			stable_q <= 1'b1;
			count_q  <= '0;
		end else if (step) begin
			last_q   <= raw;
			stable_q <= stable_d;
			count_q  <= count_d;
		end
	end

endmodule

// ===== design/dbmm_ctrl.sv =====
// Speed level and motor mode registers with the PWM duty computation.
module dbmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dbmm_pkg::btn_evt_t  evt_left,
	input  dbmm_pkg::btn_evt_t  evt_right,
	input  dbmm_pkg::btn_evt_t  evt_activate,
	output dbmm_pkg::result_t   res
);

	dbmm_pkg::mode_t                mode_q;
	dbmm_pkg::mode_t                mode_d;
	logic [dbmm_pkg::LEVEL_W-1:0]   left_q;
	logic [dbmm_pkg::LEVEL_W-1:0]   left_d;
	logic [dbmm_pkg::LEVEL_W-1:0]   right_q;
	logic [dbmm_pkg::LEVEL_W-1:0]   right_d;
	logic                           hold_both;
	logic                           act_left;
	logic                           act_right;
	logic                           act_mode;

	// Edges act in priority order and are dropped while both speed buttons are held.
	assign hold_both = !evt_left.stable && !evt_right.stable;
	assign act_left  = !hold_both && evt_left.fall;
	assign act_right = !hold_both && !evt_left.fall && evt_right.fall;
	assign act_mode  = !hold_both && !evt_left.fall && !evt_right.fall && evt_activate.fall;

	// Speed levels cycle through one to the top level.
	always_comb begin
		left_d  = act_left  ? dbmm_pkg::next_level(left_q)  : left_q;
		right_d = act_right ? dbmm_pkg::next_level(right_q) : right_q;
	end

	// Next mode: stop, left, right, then back to stop.
	always_comb begin
		mode_d = mode_q;
		if (act_mode) begin
			case (mode_q)
				dbmm_pkg::MODE_STOP:  mode_d = dbmm_pkg::MODE_LEFT;
				dbmm_pkg::MODE_LEFT:  mode_d = dbmm_pkg::MODE_RIGHT;
				default:              mode_d = dbmm_pkg::MODE_STOP;
			endcase
		end
	end

	// Result fields from the updated state; only the active side gets a duty.
	always_comb begin
		res.duty_forward = '0;
		res.duty_reverse = '0;
		case (mode_d)
			dbmm_pkg::MODE_LEFT:  res.duty_forward = dbmm_pkg::duty_of(left_d);
			dbmm_pkg::MODE_RIGHT: res.duty_reverse = dbmm_pkg::duty_of(right_d);
			default: begin
				res.duty_forward = '0;
				res.duty_reverse = '0;
			end
		endcase
		res.motor_mode  = mode_d;
		res.left_speed  = dbmm_pkg::SPEED_W'(left_d);
		res.right_speed = dbmm_pkg::SPEED_W'(right_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= dbmm_pkg::MODE_STOP;
			left_q  <= dbmm_pkg::LEVEL_FIRST;
			right_q <= dbmm_pkg::LEVEL_FIRST;
		end else if (step) begin
			mode_q  <= mode_d;
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

endmodule

// ===== design/debounced_button_motor_mode_control_core.sv =====
// Top level of the debounced button motor mode control block.
//
// Each request on the item channel is one millisecond tick carrying the raw
// active-low levels of the left, right and activate buttons. For every tick
// the block returns one request on the result channel with both PWM duties,
// the motor mode and the two speed levels after that tick.
// The cfg channel writes the debounce setting in ticks; it is always ready
// and is meant to be written only while the block is idle.
// The item is held in the input register and then processed into the result
// register by a single pass of debounce and mode logic between those two
// registers. Throughput is one tick per cycle while the receiver keeps
// taking results.
// After reset all buttons read released, counters are zero, both speed
// levels are one, the mode is stopped and the debounce setting is 50.
// When the receiver stalls, the result register holds its request, the input
// register takes one more tick if it was empty, and then item_ready drops
// until the result is taken.
module debounced_button_motor_mode_control_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  dbmm_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output dbmm_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dbmm_pkg::TICKS_W-1:0]   cfg_data
);

`include "debounced_button_motor_mode_control_core_macros.svh"

	logic                           valid_s1;
	dbmm_pkg::item_t                item_s1;
	logic                           valid_s2;
	dbmm_pkg::result_t              result_s2;
	logic [dbmm_pkg::TICKS_W-1:0]   ticks_q;
	logic                           advance;
	logic                           step;
	dbmm_pkg::btn_evt_t             evt_left;
	dbmm_pkg::btn_evt_t             evt_right;
	dbmm_pkg::btn_evt_t             evt_activate;
	dbmm_pkg::result_t              res_next;

	// Handshake: the result register frees when empty or taken.
	assign advance    = !valid_s2 || result_ready;
	assign step       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	// Debounce setting register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= dbmm_pkg::TICKS_RESET;
		end else if (cfg_valid) begin
			ticks_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	dbmm_debounce u_deb_left (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.raw    (item_s1.raw_left),
		.ticks  (ticks_q),
		.evt    (evt_left)
	);

	dbmm_debounce u_deb_right (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.raw    (item_s1.raw_right),
		.ticks  (ticks_q),
		.evt    (evt_right)
	);

	dbmm_debounce u_deb_activate (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.raw    (item_s1.raw_activate),
		.ticks  (ticks_q),
		.evt    (evt_activate)
	);

	dbmm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.evt_left     (evt_left),
		.evt_right    (evt_right),
		.evt_activate (evt_activate),
		.res          (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// An empty result register never blocks a new tick.
	`DBMM_ASSERT(a_ready_when_empty, clk, arst_n, valid_s2 || item_ready)
	// A stalled tick in the input register is kept for the next cycle.
	`DBMM_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1))
	// The forward duty is driven only in left mode.
	`DBMM_ASSERT(a_fwd_mode, clk, arst_n, !valid_s2 || result.duty_forward == '0 || result.motor_mode == dbmm_pkg::MODE_LEFT)
	// The reverse duty is driven only in right mode.
	`DBMM_ASSERT(a_rev_mode, clk, arst_n, !valid_s2 || result.duty_reverse == '0 || result.motor_mode == dbmm_pkg::MODE_RIGHT)
	// Both duties are never nonzero together.
	`DBMM_ASSERT(a_one_side, clk, arst_n, !valid_s2 || result.duty_forward == '0 || result.duty_reverse == '0)

endmodule
